@@ src/indexed_meter_link_port_macros.svh @@
// assertion macros shared by the link port rtl
`ifndef INDEXED_METER_LINK_PORT_MACROS_SVH
`define INDEXED_METER_LINK_PORT_MACROS_SVH

// property checked in the same cycle as its condition
`define IMLP_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("imlp check failed");

// property checked in the cycle after its condition
`define IMLP_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("imlp check failed");

`endif

@@ src/imlp_pkg.sv @@
// types and constants of the indexed meter link port
package imlp_pkg;

    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_READ    = 2'd1;
    localparam logic [1:0] REQ_SERVICE = 2'd2;
    localparam logic [1:0] REQ_RELOAD  = 2'd3;

    localparam logic [1:0] CFG_DAILY_POINTS   = 2'd0;
    localparam logic [1:0] CFG_BONUS_POINTS   = 2'd1;
    localparam logic [1:0] CFG_GOOD_DAY_COUNT = 2'd2;
    localparam logic [1:0] CFG_DAYS_TO_BONUS  = 2'd3;

    localparam logic [7:0] IDX_WORD_LO = 8'h20;
    localparam logic [7:0] IDX_WORD_HI = 8'h27;
    localparam logic [7:0] IDX_FLAG_LO = 8'h31;
    localparam logic [7:0] IDX_FLAG_HI = 8'h32;
    localparam logic [7:0] IDX_PUT_LO  = 8'h60;
    localparam logic [7:0] IDX_PUT_HI  = 8'h67;
    localparam logic [7:0] IDX_EXT_LO  = 8'hE0;
    localparam logic [7:0] IDX_EXT_HI  = 8'hE2;
    localparam logic [7:0] IDX_SWALLOW = 8'hE1;

    localparam logic [2:0] PUT_BYTES     = 3'd4;
    localparam logic [2:0] SWALLOW_BYTES = 3'd6;
    localparam logic [4:0] SHIFT_TOP     = 5'd24;
    localparam logic [4:0] SHIFT_STEP    = 5'd8;
    localparam logic [6:0] YEAR_ZERO     = 7'd100;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] write_byte;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day_of_month;
        logic [3:0] month_index;
        logic [6:0] year_two_digit;
    } t_req;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       irq_request;
        logic       irq_raise;
        logic       index_rejected;
    } t_result;

    typedef struct packed {
        logic [31:0] daily_points;
        logic [31:0] bonus_points;
        logic [31:0] good_day_count;
        logic [31:0] days_to_bonus;
    } t_defaults;

endpackage

@@ src/imlp_core.sv @@
// index protocol state, data words and result register
`include "indexed_meter_link_port_macros.svh"

module imlp_core
    import imlp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_req      i_req,
    input  t_defaults i_defaults,
    output logic      o_done,
    output t_result   o_result
);

    logic [7:0]  r_index;
    logic [31:0] r_words [8];
    logic [4:0]  r_shift;
    logic        r_pending;
    logic        r_reload;
    logic [2:0]  r_remaining;
    logic [31:0] r_param;
    logic        r_done;
    t_result     r_result;

    logic [7:0]  n_index;
    logic [31:0] n_words [8];
    logic [4:0]  n_shift;
    logic        n_pending;
    logic        n_reload;
    logic [2:0]  n_remaining;
    logic [31:0] n_param;
    t_result     n_result;

    logic        word_index;
    logic        put_index;
    logic        known_index;
    logic [31:0] sel_word;
    logic [31:0] shifted;
    logic [4:0]  day_packed;
    logic [6:0]  year_packed;
    logic [31:0] date_word;

    assign word_index = r_index inside {[IDX_WORD_LO:IDX_WORD_HI]};
    assign put_index  = r_index inside {[IDX_PUT_LO:IDX_PUT_HI]};
    assign known_index = i_req.write_byte inside {[IDX_WORD_LO:IDX_WORD_HI],
        [IDX_FLAG_LO:IDX_FLAG_HI], [IDX_PUT_LO:IDX_PUT_HI], [IDX_EXT_LO:IDX_EXT_HI]};

    assign sel_word = word_index ? r_words[r_index[2:0]] : 32'd0;
    assign shifted  = sel_word >> r_shift;

    // day of month zero wraps to 31, year zero stands for 100
    assign day_packed  = i_req.day_of_month - 5'd1;
    assign year_packed = (i_req.year_two_digit == 7'd0) ? YEAR_ZERO : i_req.year_two_digit;
    assign date_word   = {1'b0, year_packed, i_req.month_index, 3'b000, day_packed,
                          1'b0, i_req.hour, i_req.minute};

    always_comb begin
        n_index     = r_index;
        n_words     = r_words;
        n_shift     = r_shift;
        n_pending   = r_pending;
        n_reload    = r_reload;
        n_remaining = r_remaining;
        n_param     = r_param;
        n_result    = '0;
        case (i_req.req_type)
            REQ_WRITE: begin
                if (r_remaining != 3'd0) begin
                    // parameter byte, never checked as an index
                    n_param     = {r_param[23:0], i_req.write_byte};
                    n_remaining = r_remaining - 3'd1;
                    n_pending   = 1'b1;
                    n_reload    = 1'b1;
                    if (n_remaining == 3'd0 && put_index) begin
                        n_words[r_index[2:0]] = n_param;
                    end
                end else if (known_index) begin
                    n_index   = i_req.write_byte;
                    n_pending = 1'b1;
                    n_reload  = 1'b1;
                    if (i_req.write_byte == IDX_WORD_LO) begin
                        n_words[0] = date_word;
                    end else if (i_req.write_byte inside {[IDX_PUT_LO:IDX_PUT_HI]}) begin
                        n_param     = '0;
                        n_remaining = PUT_BYTES;
                    end else if (i_req.write_byte == IDX_SWALLOW) begin
                        n_param     = '0;
                        n_remaining = SWALLOW_BYTES;
                    end
                end else begin
                    n_index   = '0;
                    n_pending = 1'b0;
                    n_reload  = 1'b0;
                    n_result.index_rejected = 1'b1;
                end
            end
            REQ_READ: begin
                n_result.read_byte = shifted[7:0];
                if (r_shift != 5'd0) begin
                    n_pending = 1'b1;
                    n_shift   = r_shift - SHIFT_STEP;
                end
            end
            REQ_SERVICE: begin
                n_result.irq_raise = 1'b1;
                n_pending = 1'b0;
                if (r_reload) begin
                    n_shift  = word_index ? SHIFT_TOP : 5'd0;
                    n_reload = 1'b0;
                end
            end
            REQ_RELOAD: begin
                n_index     = '0;
                n_words     = '{default: 32'd0};
                n_words[1]  = i_defaults.daily_points;
                n_words[2]  = i_defaults.bonus_points;
                n_words[3]  = i_defaults.good_day_count;
                n_words[4]  = i_defaults.days_to_bonus;
                n_shift     = '0;
                n_pending   = 1'b0;
                n_reload    = 1'b0;
                n_remaining = '0;
                n_param     = '0;
            end
            default: begin
                n_result = '0;
            end
        endcase
        n_result.irq_request = n_pending;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index     <= '0;
            r_words     <= '{default: 32'd0};
            r_shift     <= '0;
            r_pending   <= 1'b0;
            r_reload    <= 1'b0;
            r_remaining <= '0;
            r_param     <= '0;
            r_done      <= 1'b0;
        end else begin
            r_done <= i_valid;
            if (i_valid) begin
                r_index     <= n_index;
                r_words     <= n_words;
                r_shift     <= n_shift;
                r_pending   <= n_pending;
                r_reload    <= n_reload;
                r_remaining <= n_remaining;
                r_param     <= n_param;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    `IMLP_ASSERT_NEXT(a_done_follows, i_valid, r_done)
    `IMLP_ASSERT_NOW(a_reject_clears_irq, r_done && r_result.index_rejected,
        !r_result.irq_request)
    `IMLP_ASSERT_NOW(a_raise_clears_irq, r_done && r_result.irq_raise, !r_result.irq_request)
    `IMLP_ASSERT_NOW(a_remaining_bound, 1'b1, r_remaining <= SWALLOW_BYTES)
    `IMLP_ASSERT_NOW(a_reload_needs_pending, r_reload, r_pending)

endmodule

@@ src/indexed_meter_link_port.sv @@
// indexed meter link port: top level with request capture and configuration registers
//
// One request is taken in every clock cycle and busy never rises. Each request
// passes an input register and then the index logic into the result register,
// so its result shows on o_result with o_done behind both registers, one result
// per request and in request order. The receiver cannot stall and must take
// every result in its strobe cycle. The four default registers feed data
// words 1 to 4 only on a reload request; write them only while no request is
// in flight. No clearing pass follows reset.
module indexed_meter_link_port
    import imlp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_done,
    output t_result     o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic      r_valid;
    t_req      r_req;
    t_defaults r_defaults;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_defaults <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DAILY_POINTS:   r_defaults.daily_points   <= i_cfg_data;
                CFG_BONUS_POINTS:   r_defaults.bonus_points   <= i_cfg_data;
                CFG_GOOD_DAY_COUNT: r_defaults.good_day_count <= i_cfg_data;
                CFG_DAYS_TO_BONUS:  r_defaults.days_to_bonus  <= i_cfg_data;
                default: begin
                    r_defaults <= r_defaults;
                end
            endcase
        end
    end

    imlp_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_valid),
        .i_req      (r_req),
        .i_defaults (r_defaults),
        .o_done     (o_done),
        .o_result   (o_result)
    );

endmodule
